// ===== sv/dhl_pkg.sv =====
// ----------------------------------------------------------------------------
// DH link chain package
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dhl_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int STG_W         = $clog2(CORDIC_STAGES + 1);

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

	function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
		logic signed [33:0] r;
		begin
			unique case (i)
				5'd0:  r = 34'sd536870912;
				5'd1:  r = 34'sd316933406;
				5'd2:  r = 34'sd167458907;
				5'd3:  r = 34'sd85004756;
				5'd4:  r = 34'sd42667331;
				5'd5:  r = 34'sd21354465;
				5'd6:  r = 34'sd10679838;
				5'd7:  r = 34'sd5340245;
				5'd8:  r = 34'sd2670163;
				5'd9:  r = 34'sd1335087;
				5'd10: r = 34'sd667544;
				5'd11: r = 34'sd333772;
				5'd12: r = 34'sd166886;
				5'd13: r = 34'sd83443;
				5'd14: r = 34'sd41722;
				5'd15: r = 34'sd20861;
				5'd16: r = 34'sd10430;
				5'd17: r = 34'sd5215;
				5'd18: r = 34'sd2608;
				5'd19: r = 34'sd1304;
				5'd20: r = 34'sd652;
				5'd21: r = 34'sd326;
				5'd22: r = 34'sd163;
				5'd23: r = 34'sd81;
				5'd24: r = 34'sd41;
				5'd25: r = 34'sd20;
				5'd26: r = 34'sd10;
				5'd27: r = 34'sd5;
				5'd28: r = 34'sd3;
				5'd29: r = 34'sd1;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/dh_link_transform_chain.sv =====
// Sequence from the accepting edge to m_tvalid: the CORDIC runs two angles on one shift-add
// unit (16 iterations plus a store each), then 42 multiply steps on one shared 32x32
// multiplier (6 link-build, 27 rotation, 9 translation products), then the output step.
// A new request is taken only after the current one is finished; the output register parts
// the sides, and the output step stalls only while the previous result is still unread.
// Reset (arst_n low): running transform to identity, no result pending.
// ----------------------------------------------------------------------------
// DH link transform chain
// Builds each link's DH transform from CORDIC sines and cosines and chains it
// onto the running 3x4 transform; reports the saturated end position.
// ----------------------------------------------------------------------------
module dh_link_transform_chain (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// link_length[31:0], link_twist[47:32], link_offset[79:48], joint_angle[95:80]
	input  logic [95:0]  s_tdata,
	// first_link
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64]
	output logic [95:0]  m_tdata,
	// overflow
	output logic         m_tuser
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CORD  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;

	// multiply step list: 0..5 build link, 6..32 rotation, 33..41 translation
	localparam logic [5:0] NSTEP = 6'd42;

	localparam int ANGLE_W = dhl_pkg::ANGLE_BITS;

	logic [2:0]  state_q;
	logic        pass_q;          // 0: theta, 1: alpha
	logic [dhl_pkg::STG_W-1:0] it_q;
	logic [5:0]  step_q;
	// row, column and term of the current matrix product
	logic [1:0]  ri_q, cj_q, kk_q;

	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [1:0]  quad_q;
	logic signed [31:0] ct_q, st_q, ca_q, sa_q;

	logic signed [31:0] a_q, d_q;
	logic [15:0] al_q;
	logic        first_q;
	logic        ovf_q;

	logic signed [31:0] rot_q [9];
	logic signed [31:0] trn_q [3];
	logic signed [31:0] lnk_q [9];
	logic signed [31:0] lt_q  [3];
	logic signed [31:0] nr_q  [9];
	logic signed [35:0] acc_q;

	logic        out_v_q;
	logic [95:0] out_d_q;
	logic        out_u_q;

	// finish a request once the output register is free or being emptied
	logic        done_go;
	assign done_go = (state_q == ST_DONE) && (!out_v_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_u_q;

	// phase of a 16-bit binary angle in units of 2^-32 turn
	function automatic logic [31:0] phase_of(input logic [15:0] ang);
		logic [ANGLE_W-1:0] m;
		begin
			m = ang[ANGLE_W-1:0];
			return {m, {(32 - ANGLE_W){1'b0}}};
		end
	endfunction

	logic [31:0] ph_in, ph_al;
	always_comb begin
		ph_in = phase_of(s_tdata[95:80]);
		ph_al = phase_of(al_q);
	end

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v,
		output logic f);
		begin
			f = 1'b0;
			if (v > 36'sd2147483647) begin
				f = 1'b1;
				return 32'sh7fffffff;
			end
			if (v < -36'sd2147483648) begin
				f = 1'b1;
				return 32'sh80000000;
			end
			return v[31:0];
		end
	endfunction

	// CORDIC shift-add unit
	logic signed [33:0] xs, ys;
	logic        zpos;
	always_comb begin
		xs   = cx_q >>> it_q;
		ys   = cy_q >>> it_q;
		zpos = !cz_q[33];
	end

	// quadrant fold of the finished CORDIC
	logic signed [31:0] fc, fs;
	always_comb begin
		unique case (quad_q)
			2'd0: begin fc = cx_q[31:0];    fs = cy_q[31:0];    end
			2'd1: begin fc = -cy_q[31:0];   fs = cx_q[31:0];    end
			2'd2: begin fc = -cx_q[31:0];   fs = -cy_q[31:0];   end
			default: begin fc = cy_q[31:0]; fs = -cx_q[31:0];   end
		endcase
	end

	// operand select for the shared multiplier
	logic signed [31:0] op_a, op_b;
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (step_q < 6'd6) begin
			unique case (step_q[2:0])
				3'd0: begin op_a = -st_q; op_b = ca_q; end
				3'd1: begin op_a = st_q;  op_b = sa_q; end
				3'd2: begin op_a = ct_q;  op_b = ca_q; end
				3'd3: begin op_a = -ct_q; op_b = sa_q; end
				3'd4: begin op_a = a_q;   op_b = ct_q; end
				default: begin op_a = a_q; op_b = st_q; end
			endcase
		end else if (step_q < 6'd33) begin
			op_a = rot_q[4'(ri_q) * 4'd3 + 4'(kk_q)];
			op_b = lnk_q[4'(kk_q) * 4'd3 + 4'(cj_q)];
		end else begin
			op_a = rot_q[4'(ri_q) * 4'd3 + 4'(kk_q)];
			op_b = lt_q[kk_q];
		end
	end

	logic signed [63:0] prod;
	logic signed [35:0] pr;
	always_comb begin
		prod = 64'(op_a) * 64'(op_b);
		pr   = 36'((prod + 64'sd536870912) >>> 30);
	end

	logic signed [35:0] sum;
	logic signed [31:0] sv;
	logic sf;
	always_comb begin
		sum = acc_q + pr;
		sv  = sat32(sum, sf);
	end

	logic signed [31:0] pv;
	logic pf;
	always_comb pv = sat32(pr, pf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			for (int i = 0; i < 9; i++)
				rot_q[i] <= (i % 4 == 0) ? dhl_pkg::ONE_Q30 : 32'sd0;
			for (int i = 0; i < 3; i++)
				trn_q[i] <= '0;
			pass_q <= 1'b0;
			it_q   <= '0;
			step_q <= '0;
			ri_q   <= '0;
			cj_q   <= '0;
			kk_q   <= '0;
		end else begin
			if (done_go)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						a_q     <= s_tdata[31:0];
						al_q    <= s_tdata[47:32];
						d_q     <= s_tdata[79:48];
						first_q <= s_tuser;
						ovf_q   <= 1'b0;
						quad_q  <= ph_in[31:30];
						cz_q    <= {4'b0, ph_in[29:0]};
						cx_q    <= dhl_pkg::CORDIC_GAIN;
						cy_q    <= '0;
						it_q    <= '0;
						pass_q  <= 1'b0;
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (it_q == dhl_pkg::STG_W'(dhl_pkg::CORDIC_STAGES)) begin
						// store, then start the next angle or the multiplies
						if (!pass_q) begin
							ct_q   <= fc;
							st_q   <= fs;
							quad_q <= ph_al[31:30];
							cz_q   <= {4'b0, ph_al[29:0]};
							cx_q   <= dhl_pkg::CORDIC_GAIN;
							cy_q   <= '0;
							it_q   <= '0;
							pass_q <= 1'b1;
						end else begin
							ca_q    <= fc;
							sa_q    <= fs;
							step_q  <= '0;
							ri_q    <= '0;
							cj_q    <= '0;
							kk_q    <= '0;
							acc_q   <= '0;
							if (first_q) begin
								for (int i = 0; i < 9; i++)
									rot_q[i] <= (i % 4 == 0) ? dhl_pkg::ONE_Q30 : 32'sd0;
								for (int i = 0; i < 3; i++)
									trn_q[i] <= '0;
							end
							state_q <= ST_MUL;
						end
					end else begin
						if (zpos) begin
							cx_q <= cx_q - ys;
							cy_q <= cy_q + xs;
							cz_q <= cz_q - dhl_pkg::atan_lut(5'(it_q));
						end else begin
							cx_q <= cx_q + ys;
							cy_q <= cy_q - xs;
							cz_q <= cz_q + dhl_pkg::atan_lut(5'(it_q));
						end
						it_q <= it_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (step_q < 6'd6) begin
						unique case (step_q[2:0])
							3'd0: lnk_q[1] <= pr[31:0];
							3'd1: lnk_q[2] <= pr[31:0];
							3'd2: lnk_q[4] <= pr[31:0];
							3'd3: lnk_q[5] <= pr[31:0];
							3'd4: begin lt_q[0] <= pv; if (pf) ovf_q <= 1'b1; end
							default: begin
								lt_q[1] <= pv;
								if (pf) ovf_q <= 1'b1;
								lt_q[2]  <= d_q;
								lnk_q[0] <= ct_q;
								lnk_q[3] <= st_q;
								lnk_q[6] <= '0;
								lnk_q[7] <= sa_q;
								lnk_q[8] <= ca_q;
							end
						endcase
						if (step_q == 6'd5)
							acc_q <= '0;
					end else if (step_q < 6'd33) begin
						// accumulate three products, then saturate silently
						if (kk_q == 2'd2)
							nr_q[4'(ri_q) * 4'd3 + 4'(cj_q)] <= sv;
						if (step_q == 6'd32)
							acc_q <= 36'(trn_q[0]);
						else if (kk_q == 2'd2)
							acc_q <= '0;
						else
							acc_q <= sum;
					end else begin
						if (kk_q == 2'd2) begin
							trn_q[ri_q] <= sv;
							if (sf) ovf_q <= 1'b1;
							if (ri_q != 2'd2)
								acc_q <= 36'(trn_q[ri_q + 2'd1]);
						end else
							acc_q <= sum;
					end
					// advance term, column and row of the product walk
					if (step_q >= 6'd6) begin
						if (kk_q != 2'd2)
							kk_q <= kk_q + 2'd1;
						else begin
							kk_q <= 2'd0;
							if (step_q < 6'd33 && cj_q != 2'd2)
								cj_q <= cj_q + 2'd1;
							else begin
								cj_q <= 2'd0;
								ri_q <= (ri_q == 2'd2) ? 2'd0 : ri_q + 2'd1;
							end
						end
					end
					if (step_q == NSTEP - 6'd1)
						state_q <= ST_DONE;
					step_q <= step_q + 6'd1;
				end
				ST_DONE: begin
					// hold here while the previous result is still unread
					if (done_go) begin
						for (int i = 0; i < 9; i++)
							rot_q[i] <= nr_q[i];
						out_d_q <= {trn_q[2], trn_q[1], trn_q[0]};
						out_u_q <= ovf_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/dh_link_transform_chain_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DH link transform chain testbench
// Drives DH link parameters over the input stream with random gaps, predicts
// the chained end position with a fixed-point model of its own and compares
// every result word against it (or a directed row's typed-in expectation), oldest first.
// ----------------------------------------------------------------------------
module dh_link_transform_chain_tb;

	typedef struct {
		logic signed [31:0] link_length;
		logic signed [15:0] link_twist;
		logic signed [31:0] link_offset;
		logic signed [15:0] joint_angle;
		logic               first_link;
	} link_req_t;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               overflow;
	} pos_res_t;

	// directed row: request plus an optional typed-in expectation
	typedef struct {
		link_req_t req;
		logic      known;
		pos_res_t  res;
	} dir_row_t;

	localparam int NUM_RANDOM = 1830;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tuser;

	// running transform of the predictor
	longint rot_q30 [9];
	longint trans_pos [3];

	pos_res_t expected_pos [$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       overflows_seen = 0;
	int       requests_sent = 0;
	bit       sink_hold = 1'b0;	// long hold-off on the result side
	bit       calm = 1'b0;	// stretch with no idling

	always #2 clk = ~clk;

	dh_link_transform_chain dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q30(longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clamp32(longint v, ref bit flag);
		if (v > longint'(S32_MAX)) begin
			flag = 1'b1;
			return longint'(S32_MAX);
		end
		if (v < longint'(S32_MIN)) begin
			flag = 1'b1;
			return longint'(S32_MIN);
		end
		return v;
	endfunction

	function automatic bit same_pos(pos_res_t p, pos_res_t q);
		return (p.pos_x === q.pos_x) && (p.pos_y === q.pos_y) &&
			(p.pos_z === q.pos_z) && (p.overflow === q.overflow);
	endfunction

	// rotation-mode CORDIC with quadrant folding, binary angle in
	task automatic angle_sincos(input logic signed [15:0] ang, output longint c,
			output longint s);
		logic [31:0] phase;
		longint x, y, z, xs, ys;
		phase = {ang[dhl_pkg::ANGLE_BITS-1:0], {(32-dhl_pkg::ANGLE_BITS){1'b0}}};
		z = longint'(phase[29:0]);
		x = longint'(dhl_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < dhl_pkg::CORDIC_STAGES && i < 30; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(dhl_pkg::atan_lut(i[4:0]));
			end else begin
				x += ys; y -= xs; z += longint'(dhl_pkg::atan_lut(i[4:0]));
			end
		end
		case (phase[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y;  s = -x; end
		endcase
	endtask

	task automatic reset_chain();
		for (int i = 0; i < 9; i++) rot_q30[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
		for (int i = 0; i < 3; i++) trans_pos[i] = 0;
	endtask

	// chain one link onto the running transform and return the end position
	task automatic chain_link(input link_req_t r, output pos_res_t p);
		longint ct, st, ca, sa, acc, a;
		longint lk [9];
		longint lt [3];
		longint nr [9];
		longint nt [3];
		bit ovf;
		ovf = 1'b0;
		a = longint'(r.link_length);
		angle_sincos(r.joint_angle, ct, st);
		angle_sincos(r.link_twist, ca, sa);
		lk[0] = ct; lk[1] = round_q30(-st * ca); lk[2] = round_q30(st * sa);
		lk[3] = st; lk[4] = round_q30(ct * ca);  lk[5] = round_q30(-ct * sa);
		lk[6] = 0;  lk[7] = sa;                  lk[8] = ca;
		lt[0] = clamp32(round_q30(a * ct), ovf);
		lt[1] = clamp32(round_q30(a * st), ovf);
		lt[2] = longint'(r.link_offset);
		if (r.first_link) reset_chain();
		for (int i = 0; i < 3; i++) begin
			bit drop;
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += round_q30(rot_q30[i*3+k] * lk[k*3+j]);
				drop = 1'b0;
				nr[i*3+j] = clamp32(acc, drop);	// rotation drift saturates silently
			end
			acc = trans_pos[i];
			for (int k = 0; k < 3; k++) acc += round_q30(rot_q30[i*3+k] * lt[k]);
			nt[i] = clamp32(acc, ovf);
		end
		rot_q30 = nr;
		trans_pos = nt;
		p.pos_x = nt[0][31:0];
		p.pos_y = nt[1][31:0];
		p.pos_z = nt[2][31:0];
		p.overflow = ovf;
	endtask

	function automatic link_req_t make_req(logic signed [31:0] a, logic signed [15:0] al,
			logic signed [31:0] d, logic signed [15:0] th, logic f);
		link_req_t r;
		r.link_length = a; r.link_twist = al; r.link_offset = d;
		r.joint_angle = th; r.first_link = f;
		return r;
	endfunction

	function automatic pos_res_t make_pos(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic o);
		pos_res_t p;
		p.pos_x = x; p.pos_y = y; p.pos_z = z; p.overflow = o;
		return p;
	endfunction

	// random request: mostly modest chains, some full-range noise
	function automatic link_req_t rand_req();
		link_req_t r;
		int mode;
		mode = $urandom_range(0, 9);
		r.link_twist = 16'($urandom);
		r.joint_angle = 16'($urandom);
		if (mode < 6) begin
			r.link_length = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			r.link_offset = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		end else begin
			r.link_length = $urandom;
			r.link_offset = $urandom;
		end
		if ($urandom_range(0, 3) == 0) r.joint_angle = 16'(16'h4000 * $urandom_range(0, 3));
		r.first_link = ($urandom_range(0, 5) == 0);
		return r;
	endfunction

	// hold valid until accepted; predict at the accepting edge
	task automatic send_link(input link_req_t r, input logic known, input pos_res_t res);
		pos_res_t p;
		while (!calm && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.joint_angle, r.link_offset, r.link_twist, r.link_length};
		s_tuser  <= r.first_link;
		do @(posedge clk); while (!s_tready);
		chain_link(r, p);
		if (known && !same_pos(p, res))
			$display("directed row expectation disagrees with predictor: %h %h %h %b",
				res.pos_x, res.pos_y, res.pos_z, res.overflow);
		expected_pos.push_back(known ? res : p);
		requests_sent++;
		// valid stays up if the next request follows at once
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_pos.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	// result side: random idling, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= !sink_hold && (calm || $urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		pos_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = make_pos(m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
			results_seen++;
			if (got.overflow) overflows_seen++;
			if (expected_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h %h %b",
					got.pos_x, got.pos_y, got.pos_z, got.overflow);
			end else begin
				want = expected_pos.pop_front();
				if (!same_pos(got, want)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: exp %h %h %h %b, got %h %h %h %b",
							results_seen, want.pos_x, want.pos_y, want.pos_z,
							want.overflow, got.pos_x, got.pos_y, got.pos_z, got.overflow);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		pos_res_t none;
		none = make_pos(0, 0, 0, 1'b0);
		reset_chain();
		// zero link after reset keeps the origin
		rows.push_back('{make_req(0, 0, 0, 0, 1'b0), 1'b1, make_pos(0, 0, 0, 1'b0)});
		// pure offset along z with no rotation
		rows.push_back('{make_req(0, 0, 32'sh00010000, 0, 1'b1), 1'b1,
			make_pos(0, 0, 32'sh00010000, 1'b0)});
		// extremes of every field
		rows.push_back('{make_req(S32_MAX, 16'sh7fff, S32_MAX, 16'sh7fff, 1'b1), 1'b0, none});
		rows.push_back('{make_req(S32_MIN, 16'sh8000, S32_MIN, 16'sh8000, 1'b1), 1'b0, none});
		rows.push_back('{make_req(S32_MAX, 0, S32_MAX, 0, 1'b0), 1'b0, none});
		rows.push_back('{make_req(S32_MAX, 0, S32_MAX, 0, 1'b0), 1'b0, none});
		rows.push_back('{make_req(S32_MIN, 0, S32_MIN, 0, 1'b0), 1'b0, none});
		rows.push_back('{make_req(-1, -1, -1, -1, 1'b0), 1'b0, none});
		// every quadrant and its boundaries for both angles
		for (int q = 0; q < 4; q++) begin
			rows.push_back('{make_req(32'sh00020000, 16'(q*16'h4000), 32'sh00008000,
				16'(q*16'h4000), 1'b0), 1'b0, none});
			rows.push_back('{make_req(32'sh00020000, 16'(q*16'h4000 + 16'h3fff), 0,
				16'(q*16'h4000 - 1), 1'b0), 1'b0, none});
		end
		// restart from identity in mid chain, then a long chain drift
		rows.push_back('{make_req(32'sh7fff0000, 16'sh1234, 32'sh00001000, 16'sh2000, 1'b1), 1'b0, none});
		rows.push_back('{make_req(32'sh7fff0000, 16'sh1234, 32'sh7fff0000, 16'sh2000, 1'b0), 1'b0, none});
		rows.push_back('{make_req(32'sh00010000, 16'sh0001, 32'sh00010000, 16'sh0001, 1'b0), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		foreach (rows[i]) begin
			row = rows[i];
			send_link(row.req, row.known, row.res);
		end
		calm = 1'b0;
		wait_drained();

		// hold the result side off while requests keep coming in
		fork
			begin
				sink_hold = 1'b1;
				repeat (400) @(posedge clk);
				sink_hold = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_link(rand_req(), 1'b0, none);
		join

		for (int i = 0; i < NUM_RANDOM; i++) begin
			calm = (i >= 600 && i < 800);
			if (i % 300 == 299) wait_drained();	// pause until all results are in
			send_link(rand_req(), 1'b0, none);
		end
		calm = 1'b0;
		wait_drained();

		$display("Sent %0d link requests, %0d results checked, %0d with overflow.",
			requests_sent, results_seen, overflows_seen);
		if (mismatches == 0 && expected_pos.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_pos.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== dh_link_transform_chain.f =====
sv/dhl_pkg.sv
sv/dh_link_transform_chain.sv
tb/dh_link_transform_chain_tb.sv
